FILE: design/b3pow_pkg.sv
`timescale 1ns / 1ps
package b3pow_pkg;
	typedef logic [31:0] word_t;
	typedef word_t [15:0] state_t;
	typedef word_t [7:0] seed_t;

	localparam int NUM_ROUNDS = 7;
	localparam int NUM_CELLS = NUM_ROUNDS * 4;
	localparam int LATENCY = NUM_CELLS + 2;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED01 = 3'd0,
		REG_SEED23 = 3'd1,
		REG_SEED45 = 3'd2,
		REG_SEED67 = 3'd3,
		REG_DIFF   = 3'd4
	} cfg_reg_t;

	localparam word_t IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};
	localparam word_t MSG_LEN_BYTES = 32'd40;
	localparam word_t BLOCK_FLAGS = 32'd11;

	localparam int PERM [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

	// message word used at position pos of round r
	function automatic int msg_idx(input int r, input int pos);
		int idx;
		idx = pos;
		for (int k = 0; k < NUM_ROUNDS; k++) begin
			if (k < r) idx = PERM[idx];
		end
		return idx;
	endfunction

	// initial compression state
	function automatic state_t init_state();
		state_t v;
		for (int i = 0; i < 8; i++) v[i] = IV[i];
		for (int i = 0; i < 4; i++) v[8+i] = IV[i];
		v[12] = '0;
		v[13] = '0;
		v[14] = MSG_LEN_BYTES;
		v[15] = BLOCK_FLAGS;
		return v;
	endfunction
endpackage

FILE: design/blake3_pow_nonce_checker.sv
`timescale 1ns / 1ps
// Checks one 64-bit nonce per clock: a single BLAKE3 compression of seed
// plus nonce, digest and a leading-zero difficulty flag. start is taken in
// every cycle (busy stays low); each result appears with done for exactly
// one cycle, in order, after a chain of 28 mixing cells (7 rounds, 4
// half-G steps each) and two stages of zero counting; the receiver cannot
// stall. Write the seed and difficulty registers only while no nonce is
// in flight.
module blake3_pow_nonce_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] nonce,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        done,
	output logic [63:0] nonce_echo,
	output logic        meets_difficulty,
	output logic [63:0] digest_01,
	output logic [63:0] digest_23,
	output logic [63:0] digest_45,
	output logic [63:0] digest_67
);
	import b3pow_pkg::*;

	logic [63:0] seed_q [4];
	logic [6:0]  difficulty_q;
	seed_t       seed;
	logic        vld_c [NUM_CELLS+1];
	logic [63:0] nonce_c [NUM_CELLS+1];
	state_t      v_c [NUM_CELLS+1];

	assign busy = 1'b0;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) seed_q[i] <= '0;
			difficulty_q <= 7'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEED01: seed_q[0] <= cfg_data;
				REG_SEED23: seed_q[1] <= cfg_data;
				REG_SEED45: seed_q[2] <= cfg_data;
				REG_SEED67: seed_q[3] <= cfg_data;
				REG_DIFF:   difficulty_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			seed[2*i] = seed_q[i][31:0];
			seed[2*i+1] = seed_q[i][63:32];
		end
	end

	assign vld_c[0] = start;
	assign nonce_c[0] = nonce;
	assign v_c[0] = init_state();

	// chain of mixing cells
	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		b3pow_cell #(
			.ROUND(c / 4),
			.DIAG((c / 2) % 2),
			.HALF(c % 2)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.seed(seed),
			.vld_in(vld_c[c]),
			.nonce_in(nonce_c[c]),
			.v_in(v_c[c]),
			.vld_out(vld_c[c+1]),
			.nonce_out(nonce_c[c+1]),
			.v_out(v_c[c+1])
		);
	end

	b3pow_lzc u_lzc (
		.clk(clk),
		.arst_n(arst_n),
		.difficulty(difficulty_q),
		.vld_in(vld_c[NUM_CELLS]),
		.nonce_in(nonce_c[NUM_CELLS]),
		.v_in(v_c[NUM_CELLS]),
		.done(done),
		.nonce_echo(nonce_echo),
		.meets_difficulty(meets_difficulty),
		.digest_01(digest_01),
		.digest_23(digest_23),
		.digest_45(digest_45),
		.digest_67(digest_67)
	);
endmodule

FILE: design/b3pow_cell.sv
`timescale 1ns / 1ps
// One half of a G step on four column or diagonal quarters.
module b3pow_cell #(
	parameter int ROUND = 0,
	parameter int DIAG = 0,
	parameter int HALF = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  b3pow_pkg::seed_t   seed,
	input  logic               vld_in,
	input  logic [63:0]        nonce_in,
	input  b3pow_pkg::state_t  v_in,
	output logic               vld_out,
	output logic [63:0]        nonce_out,
	output b3pow_pkg::state_t  v_out
);
	import b3pow_pkg::*;

	localparam int R1 = (HALF == 0) ? 16 : 8;
	localparam int R2 = (HALF == 0) ? 12 : 7;

	word_t  m [16];
	state_t v_n;

	// assemble the message block
	always_comb begin
		for (int i = 0; i < 8; i++) m[i] = seed[i];
		m[8] = nonce_in[31:0];
		m[9] = nonce_in[63:32];
		for (int i = 10; i < 16; i++) m[i] = '0;
	end

	// mix four independent quarters
	always_comb begin
		int ia, ib, ic, id;
		word_t a, b, c, d, x, t;
		v_n = v_in;
		for (int j = 0; j < 4; j++) begin
			ia = j;
			ib = 4 + ((j + DIAG) % 4);
			ic = 8 + ((j + 2 * DIAG) % 4);
			id = 12 + ((j + 3 * DIAG) % 4);
			x = m[4'(msg_idx(ROUND, 2 * (j + 4 * DIAG) + HALF))];
			a = v_in[ia];
			b = v_in[ib];
			c = v_in[ic];
			d = v_in[id];
			a = a + b + x;
			t = d ^ a;
			d = (t >> R1) | (t << (32 - R1));
			c = c + d;
			t = b ^ c;
			b = (t >> R2) | (t << (32 - R2));
			v_n[ia] = a;
			v_n[ib] = b;
			v_n[ic] = c;
			v_n[id] = d;
		end
	end

	// advance to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		nonce_out <= nonce_in;
		v_out <= v_n;
	end
endmodule

FILE: design/b3pow_lzc.sv
`timescale 1ns / 1ps
// Final xor, leading zero count in two steps, difficulty compare.
module b3pow_lzc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [6:0]        difficulty,
	input  logic              vld_in,
	input  logic [63:0]       nonce_in,
	input  b3pow_pkg::state_t v_in,
	output logic              done,
	output logic [63:0]       nonce_echo,
	output logic              meets_difficulty,
	output logic [63:0]       digest_01,
	output logic [63:0]       digest_23,
	output logic [63:0]       digest_45,
	output logic [63:0]       digest_67
);
	import b3pow_pkg::*;

	word_t       h [8];
	logic [5:0]  wcnt [8];
	logic        vld_s1;
	logic [63:0] nonce_s1;
	word_t       h_s1 [8];
	logic [5:0]  wcnt_s1 [8];
	logic [CNT_W-1:0] total;

	// per-word count, bytes in order, msb of each byte first
	always_comb begin
		logic [31:0] r;
		for (int k = 0; k < 8; k++) begin
			h[k] = v_in[k] ^ v_in[k+8];
			r = {h[k][7:0], h[k][15:8], h[k][23:16], h[k][31:24]};
			wcnt[k] = 6'd32;
			for (int i = 0; i < 32; i++) begin
				if (r[i]) wcnt[k] = 6'(31 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		nonce_s1 <= nonce_in;
		h_s1 <= h;
		wcnt_s1 <= wcnt;
	end

	// combine word counts while leading words are all zero
	always_comb begin
		logic open;
		total = '0;
		open = 1'b1;
		for (int k = 0; k < 8; k++) begin
			if (open) total = total + CNT_W'(wcnt_s1[k]);
			if (wcnt_s1[k] != 6'd32) open = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			done <= vld_s1;
		end
	end

	// hold the result for its one-cycle transfer
	always_ff @(posedge clk) begin
		nonce_echo <= nonce_s1;
		meets_difficulty <= (total >= CNT_W'(difficulty));
		digest_01 <= {h_s1[1], h_s1[0]};
		digest_23 <= {h_s1[3], h_s1[2]};
		digest_45 <= {h_s1[5], h_s1[4]};
		digest_67 <= {h_s1[7], h_s1[6]};
	end
endmodule

FILE: design/b3pow_checker.sv
`timescale 1ns / 1ps
module b3pow_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [63:0] nonce,
	input logic        done,
	input logic [63:0] nonce_echo,
	input logic [63:0] digest_01
);
	import b3pow_pkg::*;

	// every accepted nonce yields a result after the fixed latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after start");

	// no result without a matching start
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without start");

	// result carries its own nonce
	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (nonce_echo == $past(nonce, LATENCY)))
		else $error("nonce echo mismatch");

	// digest_01 is fully defined on every result
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(digest_01))
		else $error("digest unknown");
endmodule

bind blake3_pow_nonce_checker b3pow_checker u_b3pow_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.nonce(nonce),
	.done(done),
	.nonce_echo(nonce_echo),
	.digest_01(digest_01)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import b3pow_pkg::*;

	localparam int MAX_CYCLES = 400000;

	typedef struct {
		logic [63:0] nonce;
		logic        meets;
		logic [63:0] d01, d23, d45, d67;
	} hash_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] nonce;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        done;
	logic [63:0] nonce_echo;
	logic        meets_difficulty;
	logic [63:0] digest_01, digest_23, digest_45, digest_67;

	// golden copy of the configuration
	logic [63:0] seed_q [4];
	logic [6:0]  diff_q;

	logic [63:0]  pending_nonces [$];
	hash_result_t expected_hashes [$];
	int           errors;
	int           cycles;
	int           gap;
	bit           drained;

	blake3_pow_nonce_checker i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .nonce(nonce),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.nonce_echo(nonce_echo), .meets_difficulty(meets_difficulty),
		.digest_01(digest_01), .digest_23(digest_23), .digest_45(digest_45),
		.digest_67(digest_67)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one quarter-round on the working state
	function automatic void g_mix(ref logic [31:0] v [16], input int a, b, c, d,
			input logic [31:0] x, y);
		v[a] = v[a] + v[b] + x;
		v[d] = ror(v[d] ^ v[a], 16);
		v[c] = v[c] + v[d];
		v[b] = ror(v[b] ^ v[c], 12);
		v[a] = v[a] + v[b] + y;
		v[d] = ror(v[d] ^ v[a], 8);
		v[c] = v[c] + v[d];
		v[b] = ror(v[b] ^ v[c], 7);
	endfunction

	function automatic hash_result_t compress_nonce(input logic [63:0] n);
		logic [31:0] m [16];
		logic [31:0] t [16];
		logic [31:0] v [16];
		logic [31:0] h [8];
		logic [7:0]  b;
		int          lz;
		bit          found;
		hash_result_t r;
		lz = 0;
		found = 0;
		for (int i = 0; i < 4; i++) begin
			m[2*i] = seed_q[i][31:0];
			m[2*i+1] = seed_q[i][63:32];
		end
		m[8] = n[31:0];
		m[9] = n[63:32];
		for (int i = 10; i < 16; i++) m[i] = '0;
		for (int i = 0; i < 8; i++) v[i] = IV[i];
		for (int i = 0; i < 4; i++) v[8+i] = IV[i];
		v[12] = '0;
		v[13] = '0;
		v[14] = MSG_LEN_BYTES;
		v[15] = BLOCK_FLAGS;
		for (int rd = 0; rd < 7; rd++) begin
			g_mix(v, 0, 4, 8, 12, m[0], m[1]);
			g_mix(v, 1, 5, 9, 13, m[2], m[3]);
			g_mix(v, 2, 6, 10, 14, m[4], m[5]);
			g_mix(v, 3, 7, 11, 15, m[6], m[7]);
			g_mix(v, 0, 5, 10, 15, m[8], m[9]);
			g_mix(v, 1, 6, 11, 12, m[10], m[11]);
			g_mix(v, 2, 7, 8, 13, m[12], m[13]);
			g_mix(v, 3, 4, 9, 14, m[14], m[15]);
			for (int i = 0; i < 16; i++) t[i] = m[PERM[i]];
			m = t;
		end
		for (int i = 0; i < 8; i++) h[i] = v[i] ^ v[i+8];
		// count leading zeros, byte 0 first, msb of each byte first
		for (int i = 0; i < 32 && !found; i++) begin
			b = 8'(h[i/4] >> (8 * (i % 4)));
			for (int k = 7; k >= 0 && !found; k--) begin
				if (b[k]) found = 1;
				else lz++;
			end
		end
		r.nonce = n;
		r.meets = (lz >= diff_q);
		r.d01 = {h[1], h[0]};
		r.d23 = {h[3], h[2]};
		r.d45 = {h[5], h[4]};
		r.d67 = {h[7], h[6]};
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// driver: one transfer per accepted start
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			nonce <= '0;
			gap <= 0;
		end else begin
			if (start && !busy) expected_hashes.push_back(compress_nonce(nonce));
			if (start && busy) begin
				// hold the item until taken
			end else if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (pending_nonces.size() > 0) begin
				start <= 1'b1;
				nonce <= pending_nonces.pop_front();
				gap <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		hash_result_t e;
		if (arst_n && done) begin
			if (expected_hashes.size() == 0) begin
				$display("%0t: unexpected result nonce %h", $time, nonce_echo);
				errors++;
			end else begin
				e = expected_hashes.pop_front();
				if (nonce_echo !== e.nonce) begin
					$display("%0t: nonce_echo exp %h got %h", $time, e.nonce, nonce_echo);
					errors++;
				end
				if (meets_difficulty !== e.meets) begin
					$display("%0t: meets_difficulty exp %b got %b", $time, e.meets,
						meets_difficulty);
					errors++;
				end
				if (digest_01 !== e.d01) begin
					$display("%0t: digest_01 exp %h got %h", $time, e.d01, digest_01);
					errors++;
				end
				if (digest_23 !== e.d23) begin
					$display("%0t: digest_23 exp %h got %h", $time, e.d23, digest_23);
					errors++;
				end
				if (digest_45 !== e.d45) begin
					$display("%0t: digest_45 exp %h got %h", $time, e.d45, digest_45);
					errors++;
				end
				if (digest_67 !== e.d67) begin
					$display("%0t: digest_67 exp %h got %h", $time, e.d67, digest_67);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic wait_idle();
		drained = 0;
		while (!drained) begin
			@(posedge clk);
			drained = (pending_nonces.size() == 0 && !start && expected_hashes.size() == 0);
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// write enable stays high; the caller drops it after the last write
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_DIFF) diff_q = val[6:0];
		else seed_q[idx[1:0]] = val;
	endtask

	task automatic write_bad_index(input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= 3'(5 + val[1:0] % 3);
		cfg_data <= val;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic load_random_seed();
		write_reg(REG_SEED01, rand64());
		write_reg(REG_SEED23, rand64());
		write_reg(REG_SEED45, rand64());
		write_reg(REG_SEED67, rand64());
	endtask

	function automatic logic [63:0] rand_nonce();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return '0;
		if (p == 1) return '1;
		if (p == 2) return 64'd1 << $urandom_range(0, 63);
		return rand64();
	endfunction

	initial begin
		int diffs [8];
		diffs = '{1, 0, 2, 4, 64, 127, 3, 8};
		errors = 0;
		cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		seed_q = '{default: '0};
		diff_q = 7'd1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config, field extremes, single-bit and alternating patterns
		pending_nonces.push_back(64'h0);
		pending_nonces.push_back('1);
		pending_nonces.push_back(64'h1);
		pending_nonces.push_back(64'h8000_0000_0000_0000);
		pending_nonces.push_back(64'h0000_0000_FFFF_FFFF);
		pending_nonces.push_back(64'hFFFF_FFFF_0000_0000);
		pending_nonces.push_back(64'h5555_5555_5555_5555);
		pending_nonces.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		wait_idle();
		// all-ones seed, zero difficulty, stray index writes ignored
		write_reg(REG_SEED01, '1);
		write_reg(REG_SEED23, '1);
		write_reg(REG_SEED45, '1);
		write_reg(REG_SEED67, '1);
		write_reg(REG_DIFF, 64'd0);
		write_bad_index(rand64());
		write_bad_index(rand64());
		cfg_we <= 1'b0;
		for (int i = 0; i < 6; i++) pending_nonces.push_back(rand_nonce());
		wait_idle();
		// difficulty of 127 from the low seven bits, upper data bits dropped
		write_reg(REG_DIFF, 64'hFFFF_FFFF_FFFF_FF7F);
		cfg_we <= 1'b0;
		for (int i = 0; i < 6; i++) pending_nonces.push_back(rand_nonce());
		wait_idle();

		// random phases over several seeds and difficulties
		for (int ph = 0; ph < 8; ph++) begin
			load_random_seed();
			write_reg(REG_DIFF, 64'(diffs[ph]));
			cfg_we <= 1'b0;
			for (int i = 0; i < 105; i++) pending_nonces.push_back(rand_nonce());
			wait_idle();
		end

		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
